// ===== design/buddy_block_allocator_defines.svh =====
// ----------------------------------------------------------------------------
// Buddy block allocator assertion macros
// Shared assertion forms, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH

// An invariant that holds at every clock edge.
`define BBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that implies another in the next cycle.
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// Buddy block allocator package
// Types, constants and helper functions shared by the allocator modules.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int unsigned MaxBlocks = 1024;
  localparam int unsigned MaxOrder  = 20;
  localparam int unsigned IdxW      = $clog2(MaxBlocks);
  localparam int unsigned CntW      = $clog2(MaxBlocks + 1);
  localparam int unsigned OrdW      = 5;
  localparam int unsigned OwnW      = 16;
  localparam int unsigned ReqW      = 21;
  localparam logic [OrdW-1:0] TotalOrderRst = OrdW'(10);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_WALK,
    ST_SPLIT,
    ST_MARK,
    ST_LINK
  } state_e;

  typedef struct packed {
    logic [OrdW-1:0] order;
    logic            used;
    logic [OwnW-1:0] owner;
    logic [IdxW-1:0] prev;
  } entry_t;

  typedef struct packed {
    logic            d_we;
    logic [IdxW-1:0] d_addr;
    entry_t          d_data;
    logic            n_we;
    logic [IdxW-1:0] n_addr;
    logic [IdxW-1:0] n_data;
  } store_wr_t;

  // Smallest k with 2^k >= req, where a request of zero counts as one.
  function automatic logic [OrdW-1:0] req_order(input logic [ReqW-1:0] req);
    logic [ReqW-1:0] m;
    logic [OrdW-1:0] k;
    m = req - ReqW'(1);
    k = '0;
    if (req > ReqW'(1)) begin
      for (int b = 0; b < ReqW; b++) begin
        if (m[b]) k = OrdW'(b + 1);
      end
    end
    return k;
  endfunction

endpackage

// ===== design/bba_store.sv =====
// ----------------------------------------------------------------------------
// Buddy block allocator block store
// Entry memory and link memory, one registered read port shared by both.
// ----------------------------------------------------------------------------
module bba_store import bba_pkg::*; (
  input  logic            clk_i,
  input  logic [IdxW-1:0] rd_addr_i,
  input  store_wr_t       wr_i,
  output entry_t          rd_data_o,
  output logic [IdxW-1:0] rd_next_o
);

  entry_t          data_mem [MaxBlocks];
  logic [IdxW-1:0] next_mem [MaxBlocks];

  always_ff @(posedge clk_i) begin
    if (wr_i.d_we) begin
      data_mem[wr_i.d_addr] <= wr_i.d_data;
    end
    rd_data_o <= data_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.n_we) begin
      next_mem[wr_i.n_addr] <= wr_i.n_data;
    end
    rd_next_o <= next_mem[rd_addr_i];
  end

endmodule

// ===== design/buddy_block_allocator.sv =====
// ----------------------------------------------------------------------------
// Buddy block allocator
// Address-ordered buddy block list with allocate and query commands.
// ----------------------------------------------------------------------------
// Usage: a command is taken when start is high and busy is low. Opcode 0
// allocates a block of the rounded-up request for owner_id_i; opcode 1 reports
// the block at list_position_i. Each command yields one result, shown for
// exactly one cycle with done_o high; the receiver cannot stall it.
// An allocate walks the list one entry per cycle from the head, then splits
// the found block one halving per cycle, then marks it in ST_MARK and, when
// that is needed, relinks its predecessor in ST_LINK. An allocate fails when
// the walk reaches the end of the list with no free block that fits, or when
// the splits would overflow the store. A query walks the list to the entry at
// list_position_i; a position beyond the list is reported from idle without a
// walk. The next command is taken in the cycle its predecessor's result is
// shown. The list walk goes through the single read port of the block store.
// The total_order register is written over cfg_valid_i/cfg_ready_o while the
// block is idle and no command is offered; each write, and reset, rebuilds
// the list as one free block in ST_INIT, with busy high.
module buddy_block_allocator import bba_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  logic            opcode_i,
  input  logic [15:0]     owner_id_i,
  input  logic [20:0]     request_units_i,
  input  logic [9:0]      list_position_i,
  output logic            done_o,
  output logic [10:0]     block_count_o,
  output logic [15:0]     position_owner_o,
  output logic            position_allocated_o,
  output logic            position_valid_o,
  output logic            alloc_failed_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [4:0]      cfg_data_i
);

  state_e state_q, state_d;
  logic [OrdW-1:0] total_q, total_d;
  logic [IdxW-1:0] head_q, head_d;
  logic [CntW-1:0] count_q, count_d;
  op_e             op_q, op_d;
  logic [OwnW-1:0] owner_q, owner_d;
  logic [OrdW-1:0] k_q, k_d;
  logic [IdxW-1:0] pos_q, pos_d;
  logic [IdxW-1:0] j_q, j_d;
  logic [CntW-1:0] i_q, i_d;
  entry_t          cur_q, cur_d;
  logic [IdxW-1:0] nxt_q, nxt_d;
  logic [IdxW-1:0] pred_q, pred_d;
  logic            was_head_q, was_head_d;
  logic            split_q, split_d;
  logic            done_q, done_d;
  logic [OwnW-1:0] r_owner_q, r_owner_d;
  logic            r_alloc_q, r_alloc_d;
  logic            r_valid_q, r_valid_d;
  logic            r_fail_q, r_fail_d;

  logic            accept;
  logic            cfg_xfer;
  logic [IdxW-1:0] rd_addr;
  entry_t          rd_data;
  logic [IdxW-1:0] rd_next;
  store_wr_t       wr;
  logic            fit;
  logic            full;
  logic            at_end;
  logic [OrdW-1:0] init_order;

  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE) && !start;
  assign accept      = start && !busy;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign init_order  = (total_q > OrdW'(MaxOrder)) ? OrdW'(MaxOrder) : total_q;

  assign fit    = !rd_data.used && (rd_data.order >= k_q);
  assign full   = ({1'b0, count_q} + (CntW+1)'(rd_data.order - k_q)) > (CntW+1)'(MaxBlocks);
  assign at_end = (i_q == count_q);
  assign rd_addr = (state_q == ST_WALK) ? rd_next : head_q;

  bba_store u_store (
    .clk_i     (clk_i),
    .rd_addr_i (rd_addr),
    .wr_i      (wr),
    .rd_data_o (rd_data),
    .rd_next_o (rd_next)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: state_d = ST_IDLE;
      ST_IDLE: begin
        if (cfg_xfer) begin
          state_d = ST_INIT;
        end else if (accept &&
                     !(op_e'(opcode_i) == OP_QUERY && {1'b0, list_position_i} >= count_q)) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (op_q == OP_QUERY) begin
          if (i_q == {1'b0, pos_q}) state_d = ST_IDLE;
        end else if (at_end) begin
          state_d = ST_IDLE;
        end else if (fit) begin
          state_d = full ? ST_IDLE : ST_SPLIT;
        end
      end
      ST_SPLIT: if (cur_q.order == k_q) state_d = ST_MARK;
      ST_MARK:  state_d = (split_q && !was_head_q) ? ST_LINK : ST_IDLE;
      ST_LINK:  state_d = ST_IDLE;
      default:  state_d = ST_INIT;
    endcase
  end

  always_comb begin
    total_d    = total_q;
    head_d     = head_q;
    count_d    = count_q;
    op_d       = op_q;
    owner_d    = owner_q;
    k_d        = k_q;
    pos_d      = pos_q;
    j_d        = j_q;
    i_d        = i_q;
    cur_d      = cur_q;
    nxt_d      = nxt_q;
    pred_d     = pred_q;
    was_head_d = was_head_q;
    split_d    = split_q;
    done_d     = 1'b0;
    r_owner_d  = r_owner_q;
    r_alloc_d  = r_alloc_q;
    r_valid_d  = r_valid_q;
    r_fail_d   = r_fail_q;
    wr         = '0;
    case (state_q)
      ST_INIT: begin
        wr.d_we   = 1'b1;
        wr.d_addr = '0;
        wr.d_data = '{order: init_order, used: 1'b0, owner: '0, prev: '0};
        wr.n_we   = 1'b1;
        wr.n_addr = '0;
        wr.n_data = '0;
        head_d    = '0;
        count_d   = CntW'(1);
      end
      ST_IDLE: begin
        if (cfg_xfer) begin
          total_d = cfg_data_i;
        end else if (accept) begin
          op_d      = op_e'(opcode_i);
          owner_d   = owner_id_i;
          k_d       = req_order(request_units_i);
          pos_d     = list_position_i;
          j_d       = head_q;
          i_d       = '0;
          r_owner_d = '0;
          r_alloc_d = 1'b0;
          r_valid_d = 1'b0;
          r_fail_d  = 1'b0;
          if (op_e'(opcode_i) == OP_QUERY && {1'b0, list_position_i} >= count_q) begin
            done_d = 1'b1;
          end
        end
      end
      ST_WALK: begin
        if (op_q == OP_QUERY) begin
          if (i_q == {1'b0, pos_q}) begin
            r_valid_d = 1'b1;
            r_alloc_d = rd_data.used;
            r_owner_d = rd_data.used ? rd_data.owner : '0;
            done_d    = 1'b1;
          end else begin
            j_d = rd_next;
            i_d = i_q + CntW'(1);
          end
        end else if (at_end) begin
          r_fail_d = 1'b1;
          done_d   = 1'b1;
        end else if (fit) begin
          if (full) begin
            r_fail_d = 1'b1;
            done_d   = 1'b1;
          end else begin
            cur_d      = rd_data;
            pred_d     = rd_data.prev;
            was_head_d = (j_q == head_q);
            split_d    = 1'b0;
          end
        end else begin
          j_d = rd_next;
          i_d = i_q + CntW'(1);
        end
      end
      ST_SPLIT: begin
        if (cur_q.order != k_q) begin
          wr.d_we   = 1'b1;
          wr.d_addr = j_q;
          wr.d_data = '{order: cur_q.order - OrdW'(1), used: 1'b0, owner: '0,
                        prev: count_q[IdxW-1:0]};
          wr.n_we   = 1'b1;
          wr.n_addr = count_q[IdxW-1:0];
          wr.n_data = j_q;
          cur_d     = '{order: cur_q.order - OrdW'(1), used: 1'b0, owner: '0,
                        prev: cur_q.prev};
          nxt_d     = j_q;
          j_d       = count_q[IdxW-1:0];
          count_d   = count_q + CntW'(1);
          split_d   = 1'b1;
        end
      end
      ST_MARK: begin
        wr.d_we   = 1'b1;
        wr.d_addr = j_q;
        wr.d_data = '{order: cur_q.order, used: 1'b1, owner: owner_q, prev: cur_q.prev};
        wr.n_we   = split_q;
        wr.n_addr = j_q;
        wr.n_data = nxt_q;
        if (split_q && was_head_q) head_d = j_q;
        if (!(split_q && !was_head_q)) done_d = 1'b1;
      end
      ST_LINK: begin
        wr.n_we   = 1'b1;
        wr.n_addr = pred_q;
        wr.n_data = j_q;
        done_d    = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      total_q <= TotalOrderRst;
      head_q  <= '0;
      count_q <= CntW'(1);
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      head_q  <= head_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    owner_q    <= owner_d;
    k_q        <= k_d;
    pos_q      <= pos_d;
    j_q        <= j_d;
    i_q        <= i_d;
    cur_q      <= cur_d;
    nxt_q      <= nxt_d;
    pred_q     <= pred_d;
    was_head_q <= was_head_d;
    split_q    <= split_d;
    r_owner_q  <= r_owner_d;
    r_alloc_q  <= r_alloc_d;
    r_valid_q  <= r_valid_d;
    r_fail_q   <= r_fail_d;
  end

  assign done_o               = done_q;
  assign block_count_o        = count_q;
  assign position_owner_o     = r_owner_q;
  assign position_allocated_o = r_alloc_q;
  assign position_valid_o     = r_valid_q;
  assign alloc_failed_o       = r_fail_q;

`include "buddy_block_allocator_defines.svh"

  `BBA_ASSERT(a_done_idle, !done_o || !busy, "Result shown while a command is still running.")
  `BBA_ASSERT(a_count_range, count_q != '0 && count_q <= CntW'(MaxBlocks), "Block count out of range.")
  `BBA_ASSERT_NEXT(a_cfg_init, cfg_xfer, state_q == ST_INIT, "Configuration transfer did not rebuild the list.")
  `BBA_ASSERT_NEXT(a_walk_bound, state_q == ST_WALK && op_q == OP_ALLOC, i_q <= count_q, "List walk ran past the end of the list.")

endmodule

// ===== tb/sv/tb_buddy_block_allocator.sv =====
// ----------------------------------------------------------------------------
// Buddy block allocator testbench
// Drives allocate and query commands with random gaps and predicts each
// result from an address-ordered block list that it keeps itself. It also
// rewrites total_order between phases, including the saturated value and a
// phase with a long run of back-to-back unit allocations.
// ----------------------------------------------------------------------------
module tb_buddy_block_allocator;
  import bba_pkg::*;

  localparam int unsigned CycleLimit = 6000000;

  typedef struct {
    op_e         op;
    logic [15:0] owner;
    logic [20:0] req;
    logic [9:0]  pos;
  } cmd_t;

  typedef struct {
    logic [10:0] count;
    logic [15:0] owner;
    logic        allocated;
    logic        valid;
    logic        failed;
  } res_t;

  typedef struct {
    logic [4:0]  order;
    logic        used;
    logic [15:0] owner;
  } blk_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        opcode_i;
  logic [15:0] owner_id_i;
  logic [20:0] request_units_i;
  logic [9:0]  list_position_i;
  logic        done_o;
  logic [10:0] block_count_o;
  logic [15:0] position_owner_o;
  logic        position_allocated_o;
  logic        position_valid_o;
  logic        alloc_failed_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [4:0]  cfg_data_i;

  cmd_t        pending_cmds[$];
  res_t        expected_results[$];
  blk_t        block_list[$];
  int          sent_cnt;
  int          accepted_cnt;
  int          gap_left;
  int          error_cnt;
  int unsigned cycle_cnt;
  bit          no_idle;

  buddy_block_allocator dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .opcode_i            (opcode_i),
    .owner_id_i          (owner_id_i),
    .request_units_i     (request_units_i),
    .list_position_i     (list_position_i),
    .done_o              (done_o),
    .block_count_o       (block_count_o),
    .position_owner_o    (position_owner_o),
    .position_allocated_o(position_allocated_o),
    .position_valid_o    (position_valid_o),
    .alloc_failed_o      (alloc_failed_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_data_i          (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic void rebuild_list(logic [4:0] total_order);
    blk_t b;
    b.order = (total_order > MaxOrder) ? 5'(MaxOrder) : total_order;
    b.used  = 1'b0;
    b.owner = '0;
    block_list.delete();
    block_list.push_back(b);
  endfunction

  // Returns 1 when the allocation fails and leaves the list unchanged.
  function automatic bit allocate_block(logic [15:0] own, logic [20:0] req);
    int   k;
    int   idx;
    int   top;
    blk_t b;
    k   = 0;
    idx = -1;
    while (k < 31 && (longint'(1) << k) < longint'(req)) k++;
    foreach (block_list[i]) begin
      if (idx < 0 && !block_list[i].used && int'(block_list[i].order) >= k) idx = i;
    end
    if (idx < 0) return 1'b1;
    top = block_list[idx].order;
    if (block_list.size() + top - k > MaxBlocks) return 1'b1;
    block_list.delete(idx);
    b.used  = 1'b0;
    b.owner = '0;
    for (int o = top - 1; o >= k; o--) begin
      b.order = 5'(o);
      block_list.insert(idx, b);
    end
    b.order = 5'(k);
    b.used  = 1'b1;
    b.owner = own;
    block_list.insert(idx, b);
    return 1'b0;
  endfunction

  function automatic res_t predict_result(cmd_t c);
    res_t r;
    r = '{default: '0};
    if (c.op == OP_ALLOC) begin
      r.failed = allocate_block(c.owner, c.req);
    end else if (c.pos < block_list.size()) begin
      r.valid     = 1'b1;
      r.allocated = block_list[c.pos].used;
      r.owner     = block_list[c.pos].used ? block_list[c.pos].owner : 16'd0;
    end
    r.count = 11'(block_list.size());
    return r;
  endfunction

  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni) begin
      if (done_o) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected: count %0d owner %0h", $time,
                   block_count_o, position_owner_o);
          error_cnt++;
        end else begin
          e = expected_results.pop_front();
          if (block_count_o !== e.count || position_owner_o !== e.owner ||
              position_allocated_o !== e.allocated || position_valid_o !== e.valid ||
              alloc_failed_o !== e.failed) begin
            $display("%0t: mismatch expected cnt %0d own %0h alc %0b vld %0b fail %0b",
                     $time, e.count, e.owner, e.allocated, e.valid, e.failed);
            $display("%0t:            actual cnt %0d own %0h alc %0b vld %0b fail %0b",
                     $time, block_count_o, position_owner_o, position_allocated_o,
                     position_valid_o, alloc_failed_o);
            error_cnt++;
          end
        end
      end
      if (start && !busy) begin
        cmd_t c;
        c.op    = op_e'(opcode_i);
        c.owner = owner_id_i;
        c.req   = request_units_i;
        c.pos   = list_position_i;
        expected_results.push_back(predict_result(c));
        accepted_cnt++;
      end
      if (cfg_valid_i && cfg_ready_o) rebuild_list(cfg_data_i);
    end
  end

  always @(negedge clk_i) begin
    cmd_t c;
    if (rst_ni && !(start && accepted_cnt < sent_cnt)) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        c = pending_cmds.pop_front();
        opcode_i        <= c.op;
        owner_id_i      <= c.owner;
        request_units_i <= c.req;
        list_position_i <= c.pos;
        start           <= 1'b1;
        sent_cnt++;
        if (no_idle) gap_left = 0;
        else if ($urandom_range(0, 9) < 7) gap_left = $urandom_range(0, 2);
        else gap_left = $urandom_range(3, 60);
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic void add_cmd(op_e op, logic [15:0] own, logic [20:0] req,
                                  logic [9:0] pos);
    cmd_t c;
    c.op    = op;
    c.owner = own;
    c.req   = req;
    c.pos   = pos;
    pending_cmds.push_back(c);
  endfunction

  function automatic void add_random(int order, int n);
    int sel;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 2) == 0) begin
        add_cmd(OP_QUERY, 16'($urandom), 21'($urandom),
                ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 40)));
      end else begin
        sel = $urandom_range(0, 9);
        add_cmd(OP_ALLOC, 16'($urandom),
                (sel == 0) ? 21'($urandom) : (sel == 1) ? 21'd0 :
                21'($urandom_range(0, 1 << $urandom_range(0, (order > 20) ? 20 : order))),
                10'($urandom));
      end
    end
  endfunction

  task automatic drain();
    while (pending_cmds.size() > 0 || start || expected_results.size() > 0)
      @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_total_order(logic [4:0] value);
    drain();
    cfg_data_i  = value;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  initial begin
    start           = 1'b0;
    opcode_i        = 1'b0;
    owner_id_i      = '0;
    request_units_i = '0;
    list_position_i = '0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    sent_cnt        = 0;
    accepted_cnt    = 0;
    gap_left        = 0;
    error_cnt       = 0;
    cycle_cnt       = 0;
    no_idle         = 1'b0;
    rebuild_list(TotalOrderRst);
    rst_ni = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    add_cmd(OP_QUERY, 16'hFFFF, 21'h1FFFFF, 10'd0);
    add_cmd(OP_QUERY, 16'h0000, 21'd0, 10'h3FF);
    add_cmd(OP_ALLOC, 16'hFFFF, 21'd0, 10'h3FF);
    add_cmd(OP_ALLOC, 16'h0001, 21'd1, 10'd0);
    add_cmd(OP_ALLOC, 16'h0002, 21'd2, 10'd0);
    add_cmd(OP_ALLOC, 16'h0003, 21'd3, 10'd0);
    add_cmd(OP_ALLOC, 16'h0004, 21'd1024, 10'd0);
    add_cmd(OP_ALLOC, 16'h0005, 21'd1048576, 10'd0);
    add_cmd(OP_ALLOC, 16'h0006, 21'h1FFFFF, 10'd0);
    for (int p = 0; p < 12; p++) add_cmd(OP_QUERY, 16'($urandom), 21'($urandom), 10'(p));
    add_cmd(OP_ALLOC, 16'h8000, 21'd512, 10'd0);
    add_cmd(OP_ALLOC, 16'h7FFF, 21'd256, 10'd0);
    add_random(10, 150);
    drain();

    write_total_order(5'd0);
    add_random(0, 40);
    drain();

    // Saturated order, then a long run of back-to-back unit allocations.
    write_total_order(5'd31);
    no_idle = 1'b1;
    for (int i = 0; i < 250; i++) add_cmd(OP_ALLOC, 16'($urandom), 21'($urandom_range(0, 1)), 10'd0);
    drain();
    no_idle = 1'b0;
    for (int i = 0; i < 20; i++) add_cmd(OP_ALLOC, 16'($urandom), 21'($urandom), 10'd0);
    add_random(20, 30);
    drain();

    write_total_order(5'd20);
    add_random(20, 30);
    drain();

    write_total_order(5'd3);
    no_idle = 1'b1;
    add_random(3, 20);
    drain();

    no_idle = 1'b0;
    write_total_order(5'd7);
    add_random(7, 20);
    drain();

    if (error_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
